// ----- rtl/core/rtd_code_to_temperature_top_assert.svh -----
// ---------------------------------------------------------------------------
// RTD converter assertion macros
// Implication and next-cycle checks, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef RTD_CODE_TO_TEMPERATURE_TOP_ASSERT_SVH
`define RTD_CODE_TO_TEMPERATURE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RTD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rtd check failed: same-cycle implication");
// next-cycle implication
`define RTD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rtd check failed: next-cycle implication");
`else
`define RTD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RTD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/rtd_c2t_pkg.sv -----
// ---------------------------------------------------------------------------
// RTD code to temperature package
// Widths, fixed-point constants, stage schedule and shared types.
// ---------------------------------------------------------------------------
package rtd_c2t_pkg;

   localparam int TEMP_FRAC_BITS = 8;
   localparam int TEMP_W = 20;
   localparam int WORD_W = 16;
   localparam int RREF_W = 16;
   localparam int R0_W = 10;
   localparam int P_W = 31;
   localparam int N1_W = 39;
   localparam int NU_W = 40;
   localparam int DQ_W = 31;
   localparam int ROOT_W = 32;
   localparam int SREM_W = 33;
   localparam int H_W = 40;
   localparam int PP_W = H_W + 16;
   localparam int DV_W = 43;
   localparam int M_W = 50;
   localparam int ND_W = M_W + TEMP_FRAC_BITS;
   localparam int QB = TEMP_W - 1;

   // discriminant and linear term, scaled
   localparam logic [31:0] DISC_CONST = 32'd1758480889;
   localparam logic [33:0] A_SCALED = 34'(39083) << 16;

   // polynomial coefficients, scaled by 128^k, Q24
   localparam logic [63:0] K0_U = ((64'd24202 << 24) + 64'd50) / 64'd100;
   localparam logic [63:0] K1_U = ((64'd22228 << 31) + 64'd5000) / 64'd10000;
   localparam logic [63:0] K2_U = ((64'd25859 << 38) + 64'd5000000) / 64'd10000000;
   localparam logic [63:0] K3_U = ((64'd48260 << 35) + 64'd4882812) / 64'd9765625;
   localparam logic [63:0] K4_U = ((64'd28183 << 40) + 64'd122070312) / 64'd244140625;
   localparam logic [63:0] K5_U = ((64'd15243 << 45) + 64'd3051757812) / 64'd6103515625;
   localparam logic signed [H_W-1:0] HORNER_INIT = H_W'(K5_U);
   localparam logic signed [H_W-1:0] HORNER_COEF [0:4] = '{
      H_W'(-$signed(K4_U)), H_W'(-$signed(K3_U)), H_W'(K2_U), H_W'(K1_U),
      H_W'(-$signed(K0_U))};

   localparam logic signed [TEMP_W-1:0] T_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
   localparam logic signed [TEMP_W-1:0] T_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

   // stage schedule
   localparam int DIV_Q_W = 32;
   localparam int DIV_STEPS = 4;
   localparam int DIV_STAGES = DIV_Q_W / DIV_STEPS;
   localparam int SQRT_STEPS = 2;
   localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;
   localparam int HORN_STEPS = 5;
   localparam int ST_LOAD = 0;
   localparam int ST_PROD = 1;
   localparam int ST_PREP = 2;
   localparam int ST_DIV0 = 3;
   localparam int ST_SQRT_INIT = ST_DIV0 + DIV_STAGES;
   localparam int ST_SQRT0 = ST_SQRT_INIT + 1;
   localparam int ST_HORN0 = ST_SQRT0;
   localparam int ST_POLY_RND = ST_HORN0 + 2 * HORN_STEPS;
   localparam int ST_DVM = ST_SQRT0 + SQRT_STAGES;
   localparam int ST_ND = ST_DVM + 1;
   localparam int ST_DIV3_0 = ST_ND + 1;
   localparam int ST_FINAL = ST_DIV3_0 + QB;
   localparam int NUM_STAGES = ST_FINAL + 1;

   typedef struct packed {
      logic [RREF_W-1:0] rref;
      logic [R0_W-1:0]   nominal;
   } cfg_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature;
      logic                     fault;
   } rsp_type;

   typedef struct packed {
      logic                     fault;
      logic                     quad;
      logic                     sat1;
      logic                     ovf;
      logic                     hneg;
      logic [P_W-1:0]           p;
      logic [31:0]              c;
      logic [N1_W-1:0]          n1;
      logic [P_W-1:0]           pm;
      logic [R0_W-1:0]          d1_rem;
      logic [DIV_Q_W-1:0]       d1_x;
      logic [R0_W-1:0]          d2_rem;
      logic [DIV_Q_W-1:0]       d2_x;
      logic [SREM_W-1:0]        s_rem;
      logic [ROOT_W-1:0]        s_root;
      logic [ROOT_W-1:0]        s_x;
      logic [29:0]              u;
      logic signed [H_W-1:0]    h;
      logic signed [PP_W-1:0]   pp_lo;
      logic signed [PP_W-1:0]   pp_hi;
      logic signed [TEMP_W-1:0] tpoly;
      logic [DV_W-1:0]          dv;
      logic [M_W-1:0]           m;
      logic [DV_W-1:0]          d3_rem;
      logic [QB-1:0]            d3_x;
      logic signed [TEMP_W-1:0] temp;
   } pipe_type;

endpackage

// ----- rtl/core/rtd_c2t_if.sv -----
// ---------------------------------------------------------------------------
// RTD converter channel interfaces
// Valid/ready channels for sensor words and temperature results.
// ---------------------------------------------------------------------------
interface rtd_c2t_req_if import rtd_c2t_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] rtd_word;

   modport source (output valid, output rtd_word, input ready);
   modport sink (input valid, input rtd_word, output ready);
endinterface

interface rtd_c2t_rsp_if import rtd_c2t_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature;
   logic                     fault;

   modport source (output valid, output temperature, output fault, input ready);
   modport sink (input valid, input temperature, input fault, output ready);
endinterface

// ----- rtl/core/rtd_c2t_pipe.sv -----
// ---------------------------------------------------------------------------
// RTD converter datapath pipeline
// Fixed-depth pipeline: products, two dividers, square root and Horner
// polynomial in parallel, then the final quotient and result select.
// ---------------------------------------------------------------------------
module rtd_c2t_pipe import rtd_c2t_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [WORD_W-1:0] in_word,
   input  cfg_type           cfg,
   output logic              out_valid,
   output rsp_type           out_data
);

   localparam int ACC_W = PP_W + 16;
   localparam int POLY_SHIFT = 24 - TEMP_FRAC_BITS;
   localparam logic signed [ACC_W-1:0] HORN_HALF = ACC_W'(1) <<< 29;
   localparam logic signed [H_W-1:0] POLY_HALF = H_W'(1) <<< (POLY_SHIFT - 1);

   pipe_type            stage_ff [NUM_STAGES];
   pipe_type            stage_in [NUM_STAGES];
   logic [NUM_STAGES-1:0] valid_ff;

   // work of one pipeline stage, chosen by its position
   function automatic pipe_type stage_work(input int idx, input pipe_type s,
                                           input cfg_type cf);
      pipe_type                 o;
      logic [R0_W-1:0]          r0;
      logic [NU_W-1:0]          nu;
      logic [R0_W:0]            dt;
      logic [DQ_W-1:0]          dq;
      logic [SREM_W+1:0]        st;
      logic [SREM_W+1:0]        trial;
      logic [2:0]               hn;
      logic signed [ACC_W-1:0]  acc;
      logic signed [H_W-1:0]    rv;
      logic [ND_W-1:0]          nd;
      logic [DV_W:0]            qt;
      o = s;
      r0 = (cf.nominal == '0) ? R0_W'(1) : cf.nominal;
      nu = '0;
      dt = '0;
      dq = '0;
      st = '0;
      trial = '0;
      hn = '0;
      acc = '0;
      rv = '0;
      nd = '0;
      qt = '0;
      // products of the scaled resistance
      if (idx == ST_PROD) begin
         o.c = 32'(r0) * 32'd3276800;
         o.n1 = N1_W'((56'(s.p) * 56'd9240000 + (56'(r0) << 16)) >> 17);
      end
      // branch choice and divider seeds
      if (idx == ST_PREP) begin
         o.quad = 32'(s.p) >= s.c;
         o.pm = P_W'(32'(s.p) - s.c);
         o.sat1 = (s.n1 >> 31) >= N1_W'(r0);
         o.d1_rem = R0_W'(s.n1 >> DIV_Q_W);
         o.d1_x = s.n1[DIV_Q_W-1:0];
         nu = NU_W'({s.p, 8'b0}) + NU_W'(r0 >> 1);
         o.d2_rem = R0_W'(nu >> DIV_Q_W);
         o.d2_x = nu[DIV_Q_W-1:0];
      end
      // divide discriminant term and polynomial argument by R0
      if (idx >= ST_DIV0 && idx < ST_SQRT_INIT) begin
         for (int k = 0; k < DIV_STEPS; k++) begin
            dt = {o.d1_rem, o.d1_x[DIV_Q_W-1]};
            if (dt >= {1'b0, r0}) begin
               o.d1_rem = R0_W'(dt - {1'b0, r0});
               o.d1_x = {o.d1_x[DIV_Q_W-2:0], 1'b1};
            end else begin
               o.d1_rem = dt[R0_W-1:0];
               o.d1_x = {o.d1_x[DIV_Q_W-2:0], 1'b0};
            end
            dt = {o.d2_rem, o.d2_x[DIV_Q_W-1]};
            if (dt >= {1'b0, r0}) begin
               o.d2_rem = R0_W'(dt - {1'b0, r0});
               o.d2_x = {o.d2_x[DIV_Q_W-2:0], 1'b1};
            end else begin
               o.d2_rem = dt[R0_W-1:0];
               o.d2_x = {o.d2_x[DIV_Q_W-2:0], 1'b0};
            end
         end
      end
      // clamp discriminant, seed square root and Horner
      if (idx == ST_SQRT_INIT) begin
         if (s.sat1 || s.d1_x >= DISC_CONST) begin
            dq = '0;
         end else begin
            dq = DQ_W'(DISC_CONST - s.d1_x);
         end
         o.s_x = {1'b0, dq};
         o.s_rem = '0;
         o.s_root = '0;
         o.u = s.d2_x[29:0];
         o.h = HORNER_INIT;
      end
      // square root, two result bits per stage
      if (idx >= ST_SQRT0 && idx < ST_DVM) begin
         for (int k = 0; k < SQRT_STEPS; k++) begin
            st = {o.s_rem, o.s_x[ROOT_W-1:ROOT_W-2]};
            trial = {1'b0, o.s_root, 2'b01};
            if (st >= trial) begin
               o.s_rem = SREM_W'(st - trial);
               o.s_root = {o.s_root[ROOT_W-2:0], 1'b1};
            end else begin
               o.s_rem = st[SREM_W-1:0];
               o.s_root = {o.s_root[ROOT_W-2:0], 1'b0};
            end
            o.s_x = {o.s_x[ROOT_W-3:0], 2'b00};
         end
      end
      // Horner steps: partial products, then round and add coefficient
      if (idx >= ST_HORN0 && idx < ST_POLY_RND) begin
         hn = 3'((idx - ST_HORN0) >> 1);
         if (((idx - ST_HORN0) & 1) == 0) begin
            o.pp_lo = PP_W'(s.h) * $signed({1'b0, s.u[14:0]});
            o.pp_hi = PP_W'(s.h) * $signed({1'b0, s.u[29:15]});
            o.hneg = s.h[H_W-1];
         end else begin
            acc = (ACC_W'(s.pp_hi) <<< 15) + ACC_W'(s.pp_lo)
                + (s.hneg ? (HORN_HALF - ACC_W'(1)) : HORN_HALF);
            o.h = H_W'(acc >>> 30) + HORNER_COEF[hn];
         end
      end
      // polynomial result to output scale, saturated
      if (idx == ST_POLY_RND) begin
         rv = (s.h + (s.h[H_W-1] ? (POLY_HALF - H_W'(1)) : POLY_HALF)) >>> POLY_SHIFT;
         if (rv > H_W'(T_MAX)) begin
            o.tpoly = T_MAX;
         end else if (rv < H_W'(T_MIN)) begin
            o.tpoly = T_MIN;
         end else begin
            o.tpoly = TEMP_W'(rv);
         end
      end
      // divisor and dividend of the quadratic branch
      if (idx == ST_DVM) begin
         o.dv = DV_W'(DV_W'(r0) * DV_W'(A_SCALED + 34'(s.s_root)));
         o.m = M_W'(s.pm) * M_W'(400000);
      end
      // rounded dividend, overflow check, divider seed
      if (idx == ST_ND) begin
         nd = (ND_W'(s.m) << TEMP_FRAC_BITS) + ND_W'(s.dv >> 1);
         o.ovf = (nd >> QB) >= ND_W'(s.dv);
         o.d3_rem = DV_W'(nd >> QB);
         o.d3_x = nd[QB-1:0];
      end
      // final quotient, one bit per stage
      if (idx >= ST_DIV3_0 && idx < ST_FINAL) begin
         qt = {s.d3_rem, s.d3_x[QB-1]};
         if (qt >= {1'b0, s.dv}) begin
            o.d3_rem = DV_W'(qt - {1'b0, s.dv});
            o.d3_x = {s.d3_x[QB-2:0], 1'b1};
         end else begin
            o.d3_rem = qt[DV_W-1:0];
            o.d3_x = {s.d3_x[QB-2:0], 1'b0};
         end
      end
      // pick the branch result
      if (idx == ST_FINAL) begin
         if (s.fault) begin
            o.temp = '0;
         end else if (s.quad) begin
            o.temp = s.ovf ? T_MAX : $signed({1'b0, s.d3_x});
         end else begin
            o.temp = s.tpoly;
         end
      end
      return o;
   endfunction

   // load stage: fault flag and code times reference resistance
   always_comb begin
      stage_in[ST_LOAD] = '0;
      stage_in[ST_LOAD].fault = in_word[0];
      stage_in[ST_LOAD].p = P_W'(P_W'(in_word[WORD_W-1:1]) * P_W'(cfg.rref));
   end

   for (genvar j = 1; j < NUM_STAGES; j++) begin : g_stage
      always_comb begin
         stage_in[j] = stage_work(j, stage_ff[j-1], cfg);
      end
   end

   // advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NUM_STAGES-2:0], in_valid};
      end
   end

   // advance payload; hold whole pipe on stall
   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff[NUM_STAGES-1];
   assign out_data.temperature = stage_ff[NUM_STAGES-1].temp;
   assign out_data.fault = stage_ff[NUM_STAGES-1].fault;

endmodule

// ----- rtl/core/rtd_code_to_temperature_top.sv -----
// ---------------------------------------------------------------------------
// RTD code to temperature converter
// Converts RTD data words to Celsius (Callendar-Van Dusen), APB registers.
// ---------------------------------------------------------------------------
//  port      | dir | beat content
//  req_bus   | in  | rtd_word: 16-bit RTD data word, bit 0 fault flag
//  rsp_bus   | out | temperature (20 bit signed, 8 fraction bits), fault
//  APB       | in  | reference_resistance at 0x0, nominal_resistance at 0x4
//
// One beat per cycle while the skid register is empty. The datapath has 50
// pipeline stages, the first loaded when a beat is accepted, most of them
// for the 32-bit divider, the 32-bit square root and the 19-bit final
// quotient, plus the output register. Reset clears valid bits and loads register defaults.
// A stalled result moves into a skid register; the pipeline holds while the
// skid register is full, so two results can wait at the output.
`include "rtd_code_to_temperature_top_assert.svh"

module rtd_code_to_temperature_top import rtd_c2t_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   rtd_c2t_req_if.sink   req_bus,
   rtd_c2t_rsp_if.source rsp_bus,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   typedef enum logic {
      REG_REF_RES = 1'b0,
      REG_NOM_RES = 1'b1
   } reg_idx_type;

   cfg_type     cfg_ff;
   logic        pipe_en;
   logic        pipe_valid;
   rsp_type     pipe_data;
   logic        out_valid_ff;
   rsp_type     out_ff;
   logic        skid_valid_ff;
   rsp_type     skid_ff;
   logic        cfg_wr;
   logic        pop;
   logic        push;
   reg_idx_type reg_sel;

   // register file
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign reg_sel = reg_idx_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rref <= RREF_W'(36019);
         cfg_ff.nominal <= R0_W'(100);
      end else if (cfg_wr) begin
         unique case (reg_sel)
            REG_REF_RES: cfg_ff.rref <= pwdata[RREF_W-1:0];
            REG_NOM_RES: cfg_ff.nominal <= pwdata[R0_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_REF_RES: prdata = 32'(cfg_ff.rref);
         REG_NOM_RES: prdata = 32'(cfg_ff.nominal);
         default: prdata = '0;
      endcase
   end

   // pipeline moves unless the skid register holds a result
   assign pipe_en = !skid_valid_ff;
   assign req_bus.ready = pipe_en;

   rtd_c2t_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_bus.valid),
      .in_word   (req_bus.rtd_word),
      .cfg       (cfg_ff),
      .out_valid (pipe_valid),
      .out_data  (pipe_data)
   );

   assign pop = out_valid_ff && rsp_bus.ready;
   assign push = pipe_en && pipe_valid;

   // output and skid valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         out_valid_ff <= skid_valid_ff || push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // output and skid payload
   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         out_ff <= skid_valid_ff ? skid_ff : pipe_data;
      end else if (push) begin
         skid_ff <= pipe_data;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.temperature = out_ff.temperature;
   assign rsp_bus.fault = out_ff.fault;

   `RTD_ASSERT_IMP(a_fault_zero, clock, reset, rsp_bus.valid && rsp_bus.fault, rsp_bus.temperature == '0)
   `RTD_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `RTD_ASSERT_NXT(a_stall_holds_tail, clock, reset, !pipe_en && pipe_valid, pipe_valid)

endmodule
